### hdl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants for the set-associative LRU cache tag model.
// ----------------------------------------------------------------------------
package salc_pkg;

	localparam int TAG_W       = 62;
	localparam int STAMP_W     = 64;
	localparam int ADDR_W      = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int SET_OUT_W   = 6;
	localparam int TOTAL_W     = 32;

	typedef enum logic [1:0] {
		OUTC_HIT   = 2'd0,
		OUTC_MISS  = 2'd1,
		OUTC_EVICT = 2'd2
	} outcome_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SET_BITS    = 2'd0,
		CFG_OFFSET_BITS = 2'd1,
		CFG_WAYS_USED   = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic              operation;
	} req_t;

	typedef struct packed {
		outcome_t             outcome;
		logic [SET_OUT_W-1:0] set_index;
		logic [TAG_W-1:0]     tag_value;
		logic [TOTAL_W-1:0]   hit_total;
		logic [TOTAL_W-1:0]   miss_total;
		logic [TOTAL_W-1:0]   eviction_total;
		logic                 last;
	} res_t;

	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} line_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_LOOK,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic accept;
		logic clear;
		logic rd;
		logic look;
		logic scan;
		logic upd;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic hit;
		logic single_way;
		logic scan_last;
		logic out_free;
		logic modify;
	} status_t;

endpackage

### hdl/set_associative_lru_cache_top.sv
// ----------------------------------------------------------------------------
// set_associative_lru_cache_top
// Tag-only set-associative cache with LRU replacement and running totals.
// ----------------------------------------------------------------------------
// One request at a time. Each access reads its set row from a single-port
// memory, compares all ways in parallel, and on a miss scans the way stamps
// one way per cycle for the oldest. A modify request runs two accesses back
// to back. A result waits in an output register while the next request is
// taken. After reset a clearing pass writes every set row before the first
// request is taken. Configuration writes are to be made only while the block
// is idle; the block itself does not enforce this.
module set_associative_lru_cache_top #(
	parameter int MAX_SET_BITS = 6,
	parameter int WAYS         = 8,
	parameter int ADDR_WIDTH   = 64,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  salc_pkg::req_t                    req_data,
	output logic                              res_valid,
	input  logic                              res_ready,
	output salc_pkg::res_t                    res_data,
	input  logic                              cfg_write_en,
	input  logic [salc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	salc_pkg::cmd_t    cmd;
	salc_pkg::status_t status;

	salc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	salc_datapath #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.WAYS         (WAYS),
		.ADDR_WIDTH   (ADDR_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_data     (req_data),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_data     (res_data),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

### hdl/salc_ctrl.sv
// ----------------------------------------------------------------------------
// salc_ctrl
// Sequencer: clearing pass, set read, lookup, victim scan and line update.
// ----------------------------------------------------------------------------
module salc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  salc_pkg::status_t  status,
	output salc_pkg::cmd_t     cmd
);

	salc_pkg::state_t state_q;
	salc_pkg::state_t state_n;
	logic             second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= salc_pkg::ST_CLEAR;
			second_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.accept) begin
				second_q <= 1'b0;
			end else if (cmd.upd) begin
				second_q <= status.modify && !second_q;
			end
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			salc_pkg::ST_CLEAR: begin
				if (status.clr_last) state_n = salc_pkg::ST_IDLE;
			end
			salc_pkg::ST_IDLE: begin
				if (req_valid) state_n = salc_pkg::ST_READ;
			end
			salc_pkg::ST_READ: begin
				state_n = salc_pkg::ST_LOOK;
			end
			salc_pkg::ST_LOOK: begin
				if (status.hit || status.single_way) state_n = salc_pkg::ST_UPDATE;
				else state_n = salc_pkg::ST_SCAN;
			end
			salc_pkg::ST_SCAN: begin
				if (status.scan_last) state_n = salc_pkg::ST_UPDATE;
			end
			salc_pkg::ST_UPDATE: begin
				if (status.out_free) begin
					if (status.modify && !second_q) state_n = salc_pkg::ST_READ;
					else state_n = salc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = salc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready  = (state_q == salc_pkg::ST_IDLE);
		cmd.accept = (state_q == salc_pkg::ST_IDLE) && req_valid;
		cmd.clear  = (state_q == salc_pkg::ST_CLEAR);
		cmd.rd     = (state_q == salc_pkg::ST_READ);
		cmd.look   = (state_q == salc_pkg::ST_LOOK);
		cmd.scan   = (state_q == salc_pkg::ST_SCAN);
		cmd.upd    = (state_q == salc_pkg::ST_UPDATE) && status.out_free;
		cmd.last   = !status.modify || second_q;
	end

endmodule

### hdl/salc_datapath.sv
// ----------------------------------------------------------------------------
// salc_datapath
// Address split, set memory, hit compare, LRU victim scan, totals, result reg.
// ----------------------------------------------------------------------------
module salc_datapath #(
	parameter int MAX_SET_BITS = 6,
	parameter int WAYS         = 8,
	parameter int ADDR_WIDTH   = 64,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  salc_pkg::req_t                      req_data,
	output logic                                res_valid,
	input  logic                                res_ready,
	output salc_pkg::res_t                      res_data,
	input  logic                                cfg_write_en,
	input  logic [salc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  salc_pkg::cmd_t                      cmd,
	output salc_pkg::status_t                   status
);

	localparam int SET_W    = MAX_SET_BITS;
	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [salc_pkg::ADDR_W-1:0] ADDR_MASK =
		{salc_pkg::ADDR_W{1'b1}} >> (salc_pkg::ADDR_W - ADDR_WIDTH);
	localparam logic [5:0] WAYS_L  = 6'(WAYS);
	localparam logic [3:0] MAXSB_L = 4'(MAX_SET_BITS > 7 ? 7 : MAX_SET_BITS);

	// configuration
	logic [2:0] set_bits_q;
	logic [4:0] offset_bits_q;
	logic [3:0] ways_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= 3'd1;
			offset_bits_q <= 5'd4;
			ways_used_q   <= 4'd8;
		end else if (cfg_write_en) begin
			case (salc_pkg::cfg_index_t'(cfg_index))
				salc_pkg::CFG_SET_BITS:    set_bits_q    <= cfg_data[2:0];
				salc_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data[4:0];
				salc_pkg::CFG_WAYS_USED:   ways_used_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	logic [3:0]       sb;
	logic [5:0]       nw_m1_full;
	logic [WAY_W-1:0] nw_m1;

	always_comb begin
		sb = ({1'b0, set_bits_q} > MAXSB_L) ? MAXSB_L : {1'b0, set_bits_q};
		if (ways_used_q == 4'd0) nw_m1_full = 6'd0;
		else if ({2'b00, ways_used_q} > WAYS_L) nw_m1_full = WAYS_L - 6'd1;
		else nw_m1_full = {2'b00, ways_used_q} - 6'd1;
		nw_m1 = nw_m1_full[WAY_W-1:0];
	end

	// address split at request acceptance
	logic [salc_pkg::ADDR_W-1:0]  addr_m;
	logic [salc_pkg::ADDR_W-1:0]  addr_off;
	logic [salc_pkg::ADDR_W-1:0]  addr_tag;
	logic [6:0]                   tag_sh;
	logic [SET_W-1:0]             set_n;
	logic [SET_W-1:0]             set_q;
	logic [salc_pkg::TAG_W-1:0]   tag_q;
	logic                         modify_q;

	always_comb begin
		addr_m   = req_data.address & ADDR_MASK;
		addr_off = addr_m >> offset_bits_q;
		tag_sh   = {3'b000, sb} + {2'b00, offset_bits_q};
		addr_tag = addr_m >> tag_sh;
		set_n    = addr_off[SET_W-1:0] & ~({SET_W{1'b1}} << sb);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			set_q    <= set_n;
			tag_q    <= addr_tag[salc_pkg::TAG_W-1:0];
			modify_q <= req_data.operation;
		end
	end

	// set memory, one row per set, cleared by a sweep after reset
	salc_pkg::line_t [WAYS-1:0] mem_q [NUM_SETS];
	salc_pkg::line_t [WAYS-1:0] row_q;
	salc_pkg::line_t [WAYS-1:0] row_n;
	logic [SET_W-1:0]           clr_idx_q;
	logic [WAY_W-1:0]           way_q;
	logic [salc_pkg::STAMP_W-1:0] use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clear) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_comb begin
		row_n              = row_q;
		row_n[way_q].valid = 1'b1;
		row_n[way_q].tag   = tag_q;
		row_n[way_q].stamp = use_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) mem_q[clr_idx_q] <= '0;
		else if (cmd.upd) mem_q[set_q] <= row_n;
		if (cmd.rd) row_q <= mem_q[set_q];
	end

	// hit compare, lowest matching way wins
	logic [WAYS-1:0]  match;
	logic             hit;
	logic [WAY_W-1:0] hit_way;

	always_comb begin
		hit_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			match[w] = row_q[w].valid && (row_q[w].tag == tag_q) && (WAY_W'(w) <= nw_m1);
			if (match[w]) hit_way = WAY_W'(w);
		end
		hit = |match;
	end

	// LRU scan, one way per cycle; strict compare keeps the lowest way on ties
	logic                         hit_q;
	logic [salc_pkg::STAMP_W-1:0] min_q;
	logic [WAY_W-1:0]             scan_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			hit_q      <= hit;
			way_q      <= hit ? hit_way : '0;
			min_q      <= row_q[0].stamp;
			scan_idx_q <= WAY_W'(1);
		end else if (cmd.scan) begin
			if (row_q[scan_idx_q].stamp < min_q) begin
				min_q <= row_q[scan_idx_q].stamp;
				way_q <= scan_idx_q;
			end
			scan_idx_q <= scan_idx_q + 1'b1;
		end
	end

	// totals and use stamp
	logic [COUNT_WIDTH-1:0] hits_q;
	logic [COUNT_WIDTH-1:0] misses_q;
	logic [COUNT_WIDTH-1:0] evicts_q;
	logic [COUNT_WIDTH-1:0] hits_n;
	logic [COUNT_WIDTH-1:0] misses_n;
	logic [COUNT_WIDTH-1:0] evicts_n;
	logic                   evict;
	salc_pkg::outcome_t     outcome;

	always_comb begin
		evict    = !hit_q && row_q[way_q].valid;
		hits_n   = hits_q;
		misses_n = misses_q;
		evicts_n = evicts_q;
		if (hit_q) begin
			outcome = salc_pkg::OUTC_HIT;
			if (!(&hits_q)) hits_n = hits_q + 1'b1;
		end else begin
			outcome = evict ? salc_pkg::OUTC_EVICT : salc_pkg::OUTC_MISS;
			if (!(&misses_q)) misses_n = misses_q + 1'b1;
			if (evict && !(&evicts_q)) evicts_n = evicts_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_q    <= salc_pkg::STAMP_W'(1);
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
		end else if (cmd.upd) begin
			use_q    <= use_q + 1'b1;
			hits_q   <= hits_n;
			misses_q <= misses_n;
			evicts_q <= evicts_n;
		end
	end

	// result register
	logic           res_valid_q;
	salc_pkg::res_t res_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.upd) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			res_data_q.outcome        <= outcome;
			res_data_q.set_index      <= salc_pkg::SET_OUT_W'(set_q);
			res_data_q.tag_value      <= tag_q;
			res_data_q.hit_total      <= salc_pkg::TOTAL_W'(hits_n);
			res_data_q.miss_total     <= salc_pkg::TOTAL_W'(misses_n);
			res_data_q.eviction_total <= salc_pkg::TOTAL_W'(evicts_n);
			res_data_q.last           <= cmd.last;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

	always_comb begin
		status.clr_last   = &clr_idx_q;
		status.hit        = hit;
		status.single_way = (nw_m1 == '0);
		status.scan_last  = (scan_idx_q == nw_m1);
		status.out_free   = !res_valid_q || res_ready;
		status.modify     = modify_q;
	end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative LRU cache tag model. A shadow
// copy of the cache lines, stamps and totals predicts every access result;
// directed cases cover the register limits, eviction order and tag truncation,
// then randomised phases at several settings run with idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAX_SB      = 6;
	localparam int WAYS_N      = 8;
	localparam int NUM_LINES   = (1 << MAX_SB) * WAYS_N;
	localparam int TAG_POOL_N  = 12;
	localparam int HOLD_CYCLES = 120;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam logic [salc_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             req_valid;
	logic                             req_ready;
	salc_pkg::req_t                   req_data;
	logic                             res_valid;
	logic                             res_ready;
	salc_pkg::res_t                   res_data;
	logic                             cfg_write_en;
	logic [salc_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data;

	// shadow of the cache state and register file
	logic                         shadow_valid [NUM_LINES];
	logic [salc_pkg::TAG_W-1:0]   shadow_tag   [NUM_LINES];
	logic [63:0]                  shadow_stamp [NUM_LINES];
	logic [63:0]                  shadow_tick;
	logic [salc_pkg::TOTAL_W-1:0] shadow_hits;
	logic [salc_pkg::TOTAL_W-1:0] shadow_misses;
	logic [salc_pkg::TOTAL_W-1:0] shadow_evictions;
	logic [2:0]                   cfg_set_bits;
	logic [4:0]                   cfg_offset_bits;
	logic [3:0]                   cfg_ways_used;

	salc_pkg::res_t outcome_queue [$];
	logic [63:0]    tag_pool [TAG_POOL_N];
	int             n_errors = 0;
	logic           idle_on = 1'b1;
	logic           hold_off_pending = 1'b0;

	set_associative_lru_cache_top #(
		.MAX_SET_BITS(MAX_SB),
		.WAYS(WAYS_N),
		.ADDR_WIDTH(64),
		.COUNT_WIDTH(salc_pkg::TOTAL_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void clear_shadow();
		for (int i = 0; i < NUM_LINES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_tag[i]   = '0;
			shadow_stamp[i] = '0;
		end
		shadow_tick      = 64'd1;
		shadow_hits      = '0;
		shadow_misses    = '0;
		shadow_evictions = '0;
		cfg_set_bits     = 3'd1;
		cfg_offset_bits  = 5'd4;
		cfg_ways_used    = 4'd8;
	endfunction

	function automatic int unsigned eff_set_bits();
		return (32'(cfg_set_bits) > MAX_SB) ? MAX_SB : 32'(cfg_set_bits);
	endfunction

	function automatic salc_pkg::res_t lookup_access(input logic [63:0] addr,
			input logic is_last);
		int unsigned sb, ob, nw, base, victim;
		logic [63:0] shifted, oldest;
		logic [salc_pkg::TAG_W-1:0] tag;
		logic [5:0] set_sel;
		logic found;
		salc_pkg::res_t r;
		sb = eff_set_bits();
		ob = 32'(cfg_offset_bits);
		nw = (cfg_ways_used == 0) ? 1 :
			((32'(cfg_ways_used) > WAYS_N) ? WAYS_N : 32'(cfg_ways_used));
		shifted = (addr >> ob) & ((64'd1 << sb) - 64'd1);
		set_sel = shifted[5:0];
		shifted = (sb + ob >= 64) ? 64'd0 : (addr >> (sb + ob));
		tag = shifted[salc_pkg::TAG_W-1:0];
		base = 32'(set_sel) * WAYS_N;
		found = 1'b0;
		victim = 0;
		for (int w = 0; w < nw; w++) begin
			if (!found && shadow_valid[base + w] && shadow_tag[base + w] == tag) begin
				found = 1'b1;
				victim = w;
			end
		end
		if (found) begin
			if (shadow_hits != '1) shadow_hits++;
			r.outcome = salc_pkg::OUTC_HIT;
		end else begin
			// oldest stamp wins, lowest way on a tie
			oldest = shadow_stamp[base];
			for (int w = 1; w < nw; w++) begin
				if (shadow_stamp[base + w] < oldest) begin
					oldest = shadow_stamp[base + w];
					victim = w;
				end
			end
			if (shadow_misses != '1) shadow_misses++;
			r.outcome = salc_pkg::OUTC_MISS;
			if (shadow_valid[base + victim]) begin
				if (shadow_evictions != '1) shadow_evictions++;
				r.outcome = salc_pkg::OUTC_EVICT;
			end
			shadow_valid[base + victim] = 1'b1;
			shadow_tag[base + victim]   = tag;
		end
		shadow_stamp[base + victim] = shadow_tick;
		shadow_tick++;
		r.set_index      = set_sel;
		r.tag_value      = tag;
		r.hit_total      = shadow_hits;
		r.miss_total     = shadow_misses;
		r.eviction_total = shadow_evictions;
		r.last           = is_last;
		return r;
	endfunction

	function automatic void predict_request(input salc_pkg::req_t r);
		if (r.operation) begin
			outcome_queue.push_back(lookup_access(r.address, 1'b0));
		end
		outcome_queue.push_back(lookup_access(r.address, 1'b1));
	endfunction

	function automatic logic [63:0] pick_address();
		int unsigned sb, ob, k;
		logic [63:0] t, s, off;
		sb = eff_set_bits();
		ob = 32'(cfg_offset_bits);
		k = $urandom_range(0, 99);
		if (k < 12) return {$urandom, $urandom};
		t = tag_pool[$urandom_range(0, TAG_POOL_N - 1)];
		s = 64'($urandom_range(0, (1 << sb) - 1));
		// keep nearly half the traffic on sets 0 to 3 so lines get reused
		if (k < 60) s = s & 64'd3;
		off = {$urandom, $urandom} & ((64'd1 << ob) - 64'd1);
		return (t << (sb + ob)) | (s << ob) | off;
	endfunction

	function automatic void refresh_tag_pool();
		for (int i = 0; i < TAG_POOL_N; i++) begin
			tag_pool[i] = (i < 9) ? 64'(i) : {$urandom, $urandom};
		end
	endfunction

	task automatic send_request(input logic [63:0] addr, input logic op);
		salc_pkg::req_t r;
		int gap;
		r.address = addr;
		r.operation = op;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 13);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		predict_request(r);
	endtask

	task automatic drain_requests();
		@(negedge clk);
		req_valid <= 1'b0;
		@(posedge clk);
		while (outcome_queue.size() != 0 || !req_ready) @(posedge clk);
	endtask

	task automatic write_register(input logic [salc_pkg::CFG_INDEX_W-1:0] idx,
			input logic [salc_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			salc_pkg::CFG_SET_BITS:    cfg_set_bits    = val[2:0];
			salc_pkg::CFG_OFFSET_BITS: cfg_offset_bits = val[4:0];
			salc_pkg::CFG_WAYS_USED:   cfg_ways_used   = val[3:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input logic [salc_pkg::CFG_DATA_W-1:0] sb,
			input logic [salc_pkg::CFG_DATA_W-1:0] ob,
			input logic [salc_pkg::CFG_DATA_W-1:0] nw);
		drain_requests();
		write_register(salc_pkg::CFG_SET_BITS, sb);
		write_register(salc_pkg::CFG_OFFSET_BITS, ob);
		write_register(salc_pkg::CFG_WAYS_USED, nw);
	endtask

	task automatic test_reset_geometry();
		drain_requests();
		send_request(64'd0, 1'b0);
		send_request(64'd0, 1'b1);
		send_request('1, 1'b0);
		send_request('1, 1'b1);
		send_request(64'h8000_0000_0000_0010, 1'b1);
	endtask

	task automatic test_lru_eviction();
		set_geometry(5'd0, 5'd1, 5'd2);
		send_request(64'd1 << 1, 1'b0);
		send_request(64'd2 << 1, 1'b0);
		send_request(64'd3 << 1, 1'b0);
		send_request(64'd1 << 1, 1'b0);
		send_request(64'd2 << 1, 1'b0);
		send_request(64'd4 << 1, 1'b1);
	endtask

	task automatic test_way_limits();
		set_geometry(5'd0, 5'd1, 5'd0);
		send_request(64'd5 << 1, 1'b0);
		send_request(64'd6 << 1, 1'b0);
		send_request(64'd5 << 1, 1'b1);
		drain_requests();
		write_register(salc_pkg::CFG_WAYS_USED, 5'd15);
		send_request(64'd7 << 1, 1'b0);
	endtask

	task automatic test_set_offset_limits();
		// set bits saturate, spare index must leave the registers alone
		set_geometry(5'b11111, 5'b11111, 5'd8);
		write_register(CFG_SPARE, 5'b10101);
		send_request('1, 1'b0);
		send_request(64'hA5A5_5A5A_0123_4567, 1'b1);
	endtask

	task automatic test_tag_truncation();
		set_geometry(5'd0, 5'd0, 5'd4);
		send_request(64'hC000_0000_0000_0001, 1'b0);
		send_request(64'h0000_0000_0000_0001, 1'b0);
	endtask

	task automatic test_random_settings();
		int unsigned phase_sb [6] = '{0, 7, 1, 6, 3, 2};
		int unsigned phase_ob [6] = '{0, 31, 1, 16, 5, 2};
		int unsigned phase_nw [6] = '{0, 15, 1, 8, 4, 3};
		for (int p = 0; p < 8; p++) begin
			if (p < 6) begin
				set_geometry(salc_pkg::CFG_DATA_W'(phase_sb[p]),
					salc_pkg::CFG_DATA_W'(phase_ob[p]),
					salc_pkg::CFG_DATA_W'(phase_nw[p]));
			end else begin
				set_geometry(salc_pkg::CFG_DATA_W'($urandom_range(0, 7)),
					salc_pkg::CFG_DATA_W'($urandom_range(0, 31)),
					salc_pkg::CFG_DATA_W'($urandom_range(0, 15)));
			end
			refresh_tag_pool();
			repeat (62) send_request(pick_address(), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_backpressure();
		drain_requests();
		hold_off_pending = 1'b1;
		repeat (14) send_request(pick_address(), 1'($urandom_range(0, 1)));
		drain_requests();
	endtask

	task automatic test_steady_stream();
		idle_on = 1'b0;
		set_geometry(5'd2, 5'd3, 5'd4);
		refresh_tag_pool();
		repeat (120) send_request(pick_address(), 1'($urandom_range(0, 1)));
	endtask

	// result side: random stalls plus one long hold-off on request
	initial begin
		int n;
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 13);
				res_ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		salc_pkg::res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (outcome_queue.size() == 0) begin
				$error("result with none expected: outcome %0d set %0d tag %h",
					res_data.outcome, res_data.set_index, res_data.tag_value);
				n_errors++;
			end else begin
				want = outcome_queue.pop_front();
				if (res_data.outcome !== want.outcome) begin
					$error("outcome: expected %0d, got %0d", want.outcome, res_data.outcome);
					n_errors++;
				end
				if (res_data.set_index !== want.set_index) begin
					$error("set_index: expected %0d, got %0d", want.set_index,
						res_data.set_index);
					n_errors++;
				end
				if (res_data.tag_value !== want.tag_value) begin
					$error("tag_value: expected %h, got %h", want.tag_value,
						res_data.tag_value);
					n_errors++;
				end
				if (res_data.hit_total !== want.hit_total) begin
					$error("hit_total: expected %0d, got %0d", want.hit_total,
						res_data.hit_total);
					n_errors++;
				end
				if (res_data.miss_total !== want.miss_total) begin
					$error("miss_total: expected %0d, got %0d", want.miss_total,
						res_data.miss_total);
					n_errors++;
				end
				if (res_data.eviction_total !== want.eviction_total) begin
					$error("eviction_total: expected %0d, got %0d", want.eviction_total,
						res_data.eviction_total);
					n_errors++;
				end
				if (res_data.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, res_data.last);
					n_errors++;
				end
			end
		end
	end

	// watchdog on cycles with no request or result moving
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (res_valid && res_ready)) quiet = 0;
			else quiet++;
		end
		$display("set_associative_lru_cache_top: mismatch");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req_data     = '0;
		cfg_write_en = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		clear_shadow();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_geometry();
		test_lru_eviction();
		test_way_limits();
		test_set_offset_limits();
		test_tag_truncation();
		test_random_settings();
		test_backpressure();
		test_steady_stream();

		drain_requests();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (outcome_queue.size() != 0) begin
			$error("%0d results never arrived", outcome_queue.size());
			n_errors++;
		end
		if (n_errors == 0) begin
			$display("set_associative_lru_cache_top: match");
		end else begin
			$display("set_associative_lru_cache_top: mismatch");
		end
		$finish;
	end

endmodule
